@@ rtl/atab_pkg.sv @@
package atab_pkg;

    // Field widths
    localparam int LBA_W   = 28;
    localparam int COUNT_W = 9;
    localparam int BYTE_W  = 8;
    localparam int ADDR_W  = 3;
    localparam int HEAD_W  = 5;

    // Division pipeline shape
    localparam int DIV_BITS_PER_STAGE = 4;
    localparam int DIV_STAGES         = LBA_W / DIV_BITS_PER_STAGE;

    // Writes issued per accepted request
    localparam int WRITES_PER_REQ = 6;
    localparam int SEQ_W          = 3;

    // Configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    typedef enum logic [1:0] {
        CFG_LBA_MODE = 2'd0,
        CFG_SPT      = 2'd1,
        CFG_HEADS    = 2'd2
    } t_cfg_idx;

    // Task-file register indexes
    localparam logic [ADDR_W-1:0] TF_NONE  = 3'd0;
    localparam logic [ADDR_W-1:0] TF_COUNT = 3'd2;
    localparam logic [ADDR_W-1:0] TF_ADDR0 = 3'd3;
    localparam logic [ADDR_W-1:0] TF_ADDR1 = 3'd4;
    localparam logic [ADDR_W-1:0] TF_ADDR2 = 3'd5;
    localparam logic [ADDR_W-1:0] TF_DEV   = 3'd6;
    localparam logic [ADDR_W-1:0] TF_CMD   = 3'd7;

    // Register values
    localparam logic [BYTE_W-1:0] CMD_READ    = 8'h20;
    localparam logic [BYTE_W-1:0] CMD_WRITE   = 8'h30;
    localparam logic [BYTE_W-1:0] DEV_LBA     = 8'hE0;
    localparam logic [BYTE_W-1:0] DEV_CHS     = 8'hA0;
    localparam logic [BYTE_W-1:0] NIBBLE_MASK = 8'h0F;

    typedef struct packed {
        logic               operation;
        logic [LBA_W-1:0]   block_address;
        logic [COUNT_W-1:0] sector_count;
    } t_req;

    typedef struct packed {
        logic [ADDR_W-1:0] reg_address;
        logic [BYTE_W-1:0] reg_value;
        logic              last;
        logic              rejected;
    } t_res;

    // Request data that rides alongside the divider
    typedef struct packed {
        logic              operation;
        logic [LBA_W-1:0]  lba;
        logic [BYTE_W-1:0] count_byte;
        logic              rejected;
        logic              lba_mode;
        logic [BYTE_W-1:0] heads;
        logic [BYTE_W-1:0] sector;
    } t_side;

    // Restoring divider state: work holds dividend bits, then quotient bits
    typedef struct packed {
        logic [LBA_W-1:0]  work;
        logic [BYTE_W-1:0] rem;
        logic [BYTE_W-1:0] divisor;
    } t_div;

    typedef struct packed {
        logic  vld;
        t_side side;
        t_div  div;
    } t_stage;

endpackage

@@ rtl/atab_div_stage.sv @@
module atab_div_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  atab_pkg::t_stage i_stg,
    output atab_pkg::t_stage o_stg
);

    logic [atab_pkg::LBA_W-1:0]  n_work;
    logic [atab_pkg::BYTE_W-1:0] n_rem;
    logic [atab_pkg::BYTE_W:0]   trial;
    atab_pkg::t_stage            r_stg;

    // Retire four quotient bits (DIV_BITS_PER_STAGE), one compare and subtract each
    always_comb begin
        n_work = i_stg.div.work;
        n_rem  = i_stg.div.rem;
        trial  = '0;
        for (int k = 0; k < atab_pkg::DIV_BITS_PER_STAGE; k++) begin
            trial  = {n_rem, n_work[atab_pkg::LBA_W-1]};
            n_work = {n_work[atab_pkg::LBA_W-2:0], 1'b0};
            if (trial >= {1'b0, i_stg.div.divisor}) begin
                trial     = trial - {1'b0, i_stg.div.divisor};
                n_work[0] = 1'b1;
            end
            n_rem = trial[atab_pkg::BYTE_W-1:0];
        end
    end

    // Hold the stage result; only the valid bit is reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg.vld <= 1'b0;
        end else begin
            r_stg.vld <= i_stg.vld;
        end
        r_stg.side        <= i_stg.side;
        r_stg.div.work    <= n_work;
        r_stg.div.rem     <= n_rem;
        r_stg.div.divisor <= i_stg.div.divisor;
    end

    assign o_stg = r_stg;

endmodule

@@ rtl/atab_serial.sv @@
module atab_serial (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  atab_pkg::t_stage i_stg,
    output logic             o_res_strobe,
    output atab_pkg::t_res   o_res
);

    atab_pkg::t_res              n_list [atab_pkg::WRITES_PER_REQ];
    atab_pkg::t_res              r_queue [atab_pkg::WRITES_PER_REQ-1];
    atab_pkg::t_res              r_res;
    logic                        r_strobe;
    logic [atab_pkg::SEQ_W-1:0]  r_left;
    logic [atab_pkg::BYTE_W-1:0] addr0, addr1, addr2, dev, cmd;

    // Pick the address bytes for the selected addressing mode
    always_comb begin
        if (i_stg.side.lba_mode) begin
            addr0 = i_stg.side.lba[7:0];
            addr1 = i_stg.side.lba[15:8];
            addr2 = i_stg.side.lba[23:16];
            dev   = atab_pkg::DEV_LBA | {4'h0, i_stg.side.lba[27:24]};
        end else begin
            addr0 = i_stg.side.sector;
            addr1 = i_stg.div.work[7:0];
            addr2 = i_stg.div.work[15:8];
            dev   = atab_pkg::DEV_CHS | (i_stg.div.rem & atab_pkg::NIBBLE_MASK);
        end
        cmd = i_stg.side.operation ? atab_pkg::CMD_WRITE : atab_pkg::CMD_READ;
    end

    // Build the write list; a refused request gives a single marked item
    always_comb begin
        if (i_stg.side.rejected) begin
            n_list[0] = '{reg_address: atab_pkg::TF_NONE, reg_value: '0,
                          last: 1'b1, rejected: 1'b1};
        end else begin
            n_list[0] = '{reg_address: atab_pkg::TF_COUNT,
                          reg_value: i_stg.side.count_byte, last: 1'b0, rejected: 1'b0};
        end
        n_list[1] = '{reg_address: atab_pkg::TF_ADDR0, reg_value: addr0,
                      last: 1'b0, rejected: 1'b0};
        n_list[2] = '{reg_address: atab_pkg::TF_ADDR1, reg_value: addr1,
                      last: 1'b0, rejected: 1'b0};
        n_list[3] = '{reg_address: atab_pkg::TF_ADDR2, reg_value: addr2,
                      last: 1'b0, rejected: 1'b0};
        n_list[4] = '{reg_address: atab_pkg::TF_DEV, reg_value: dev,
                      last: 1'b0, rejected: 1'b0};
        n_list[5] = '{reg_address: atab_pkg::TF_CMD, reg_value: cmd,
                      last: 1'b1, rejected: 1'b0};
    end

    // Emit the first item on load, then shift the rest out one per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
            r_left   <= '0;
        end else if (i_stg.vld) begin
            r_strobe <= 1'b1;
            r_left   <= i_stg.side.rejected ? '0
                      : atab_pkg::SEQ_W'(atab_pkg::WRITES_PER_REQ - 1);
        end else if (r_left != '0) begin
            r_strobe <= 1'b1;
            r_left   <= r_left - 1'b1;
        end else begin
            r_strobe <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_stg.vld) begin
            r_res <= n_list[0];
            for (int k = 0; k < atab_pkg::WRITES_PER_REQ - 1; k++) begin
                r_queue[k] <= n_list[k+1];
            end
        end else if (r_left != '0) begin
            r_res <= r_queue[0];
            for (int k = 0; k < atab_pkg::WRITES_PER_REQ - 2; k++) begin
                r_queue[k] <= r_queue[k+1];
            end
        end
    end

    assign o_res_strobe = r_strobe;
    assign o_res        = r_res;

endmodule

@@ rtl/ata_taskfile_address_builder.sv @@
// Turns a sector read or write request into the six ATA task-file writes
// (count, three address bytes, device/head, command) that start it. A request
// is taken when start is high and busy is low; busy then stays high so that
// requests are spaced by the time the single result port needs for six writes.
// In CHS mode the address is split by two 28-step restoring divisions (by
// sectors per track, then by head count), each run through a seven-stage
// pipeline at four quotient bits per stage. A taken request is registered,
// passes both divider pipelines and is loaded into the output register, which
// shows the first write; the rest follow on consecutive cycles, each shown for
// exactly one cycle with o_res_strobe high. The receiver cannot stall: it must
// take every write as it comes. A zero count, or one above 256, gives a single
// write marked rejected and last. Configuration must only change while no
// request is in flight.
module ata_taskfile_address_builder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  atab_pkg::t_req                 i_req,
    output logic                           o_res_strobe,
    output atab_pkg::t_res                 o_res,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [atab_pkg::PADDR_W-1:0]   paddr,
    input  logic [atab_pkg::PDATA_W-1:0]   pwdata,
    output logic [atab_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);

    logic                          r_lba_mode;
    logic [atab_pkg::BYTE_W-1:0]   r_spt;
    logic [atab_pkg::HEAD_W-1:0]   r_heads;
    logic [atab_pkg::SEQ_W-1:0]    r_busy_cnt;
    logic                          accept;
    logic                          cfg_wr;
    atab_pkg::t_cfg_idx            cfg_idx;
    logic                          req_bad;
    atab_pkg::t_stage              r_in;
    atab_pkg::t_stage              w_a [atab_pkg::DIV_STAGES+1];
    atab_pkg::t_stage              w_b [atab_pkg::DIV_STAGES+1];

    assign accept  = start && !busy;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = atab_pkg::t_cfg_idx'(paddr[3:2]);
    assign pready  = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lba_mode <= 1'b1;
            r_spt      <= 8'd63;
            r_heads    <= 5'd16;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                atab_pkg::CFG_LBA_MODE: r_lba_mode <= pwdata[0];
                atab_pkg::CFG_SPT:      r_spt      <= pwdata[atab_pkg::BYTE_W-1:0];
                atab_pkg::CFG_HEADS:    r_heads    <= pwdata[atab_pkg::HEAD_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (cfg_idx)
            atab_pkg::CFG_LBA_MODE: prdata = {31'd0, r_lba_mode};
            atab_pkg::CFG_SPT:      prdata = {24'd0, r_spt};
            atab_pkg::CFG_HEADS:    prdata = {27'd0, r_heads};
            default:                prdata = '0;
        endcase
    end

    // Pace requests so that their write runs do not overlap on the result port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy_cnt <= '0;
        end else if (accept) begin
            r_busy_cnt <= atab_pkg::SEQ_W'(atab_pkg::WRITES_PER_REQ - 1);
        end else if (r_busy_cnt != '0) begin
            r_busy_cnt <= r_busy_cnt - 1'b1;
        end
    end

    assign busy = (r_busy_cnt != '0);

    assign req_bad = (i_req.sector_count == '0)
                  || (i_req.sector_count[8] && (i_req.sector_count[7:0] != '0));

    // Capture the request and seed the first division
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.vld <= 1'b0;
        end else begin
            r_in.vld <= accept;
        end
        r_in.side.operation  <= i_req.operation;
        r_in.side.lba        <= i_req.block_address;
        r_in.side.count_byte <= i_req.sector_count[7:0];
        r_in.side.rejected   <= req_bad;
        r_in.side.lba_mode   <= r_lba_mode;
        r_in.side.heads      <= (r_heads == '0) ? 8'd1 : {3'd0, r_heads};
        r_in.side.sector     <= '0;
        r_in.div.work        <= i_req.block_address;
        r_in.div.rem         <= '0;
        r_in.div.divisor     <= (r_spt == '0) ? 8'd1 : r_spt;
    end

    // Track number and sector within the track
    assign w_a[0] = r_in;

    for (genvar g = 0; g < atab_pkg::DIV_STAGES; g++) begin : g_div_a
        atab_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stg   (w_a[g]),
            .o_stg   (w_a[g+1])
        );
    end

    // Hand the track number on as the next dividend, keep the 1-based sector
    always_comb begin
        w_b[0]             = w_a[atab_pkg::DIV_STAGES];
        w_b[0].side.sector = w_a[atab_pkg::DIV_STAGES].div.rem + 1'b1;
        w_b[0].div.rem     = '0;
        w_b[0].div.divisor = w_a[atab_pkg::DIV_STAGES].side.heads;
    end

    // Cylinder and head
    for (genvar g = 0; g < atab_pkg::DIV_STAGES; g++) begin : g_div_b
        atab_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stg   (w_b[g]),
            .o_stg   (w_b[g+1])
        );
    end

    atab_serial u_serial (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_stg        (w_b[atab_pkg::DIV_STAGES]),
        .o_res_strobe (o_res_strobe),
        .o_res        (o_res)
    );

    // A refused request yields one item, which closes the run
    a_rejected_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && o_res.rejected) |-> o_res.last)
        else $error("rejected item without last");

    // The closing write of an accepted request is the command register
    a_last_is_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && o_res.last && !o_res.rejected)
            |-> (o_res.reg_address == atab_pkg::TF_CMD))
        else $error("run ended on a register other than command");

    // A taken request keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("busy not raised after a request was taken");

    // A command write is followed by silence or a new run's first write
    a_cmd_then_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && (o_res.reg_address == atab_pkg::TF_CMD))
            |=> (!o_res_strobe || (o_res.reg_address == atab_pkg::TF_COUNT)
                 || o_res.rejected))
        else $error("write issued after the command write");

endmodule

@@ tb/sv/tb_top.sv @@
module tb_top;
    import atab_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int TAIL_CYCLES  = 24;

    // Predicts the task-file writes for each request and checks them in order
    class taskfile_scoreboard;
        t_res        expected_writes[$];
        logic        lba_mode;
        logic [7:0]  spt;
        logic [4:0]  heads;
        int          errors;

        function new();
            lba_mode = 1'b1;
            spt      = 8'd63;
            heads    = 5'd16;
            errors   = 0;
        endfunction

        function void set_register(t_cfg_idx idx, logic [31:0] value);
            case (idx)
                CFG_LBA_MODE: lba_mode = value[0];
                CFG_SPT:      spt      = value[7:0];
                CFG_HEADS:    heads    = value[4:0];
                default:      ;
            endcase
        endfunction

        function void push_write(logic [2:0] addr, logic [7:0] value, logic last,
                                 logic rejected);
            t_res w;
            w.reg_address = addr;
            w.reg_value   = value;
            w.last        = last;
            w.rejected    = rejected;
            expected_writes.push_back(w);
        endfunction

        // Work out the six writes, or the single refusal, for one item
        function void note_request(t_req r);
            int unsigned lba, spt_eff, heads_eff, track, sector, head, cylinder;
            logic [7:0]  addr_lo, addr_mid, addr_hi, dev;
            lba = {4'd0, r.block_address};
            if (r.sector_count == 0 || r.sector_count > 256) begin
                push_write(TF_NONE, 8'h00, 1'b1, 1'b1);
                return;
            end
            if (lba_mode) begin
                addr_lo  = lba[7:0];
                addr_mid = lba[15:8];
                addr_hi  = lba[23:16];
                dev      = DEV_LBA | {4'h0, lba[27:24]};
            end else begin
                // treat a zero geometry value as one
                spt_eff   = (spt == 0) ? 1 : spt;
                heads_eff = (heads == 0) ? 1 : heads;
                track     = lba / spt_eff;
                sector    = lba % spt_eff + 1;
                head      = track % heads_eff;
                cylinder  = (track / heads_eff) & 32'hFFFF;
                addr_lo   = sector[7:0];
                addr_mid  = cylinder[7:0];
                addr_hi   = cylinder[15:8];
                dev       = DEV_CHS | (head[7:0] & NIBBLE_MASK);
            end
            push_write(TF_COUNT, r.sector_count[7:0], 1'b0, 1'b0);
            push_write(TF_ADDR0, addr_lo, 1'b0, 1'b0);
            push_write(TF_ADDR1, addr_mid, 1'b0, 1'b0);
            push_write(TF_ADDR2, addr_hi, 1'b0, 1'b0);
            push_write(TF_DEV, dev, 1'b0, 1'b0);
            push_write(TF_CMD, r.operation ? CMD_WRITE : CMD_READ, 1'b1, 1'b0);
        endfunction

        task report_mismatch(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_write(t_res got);
            t_res exp;
            if (expected_writes.size() == 0) begin
                report_mismatch($sformatf("unexpected write reg %0d value %02h",
                                          got.reg_address, got.reg_value));
                return;
            end
            exp = expected_writes.pop_front();
            if (got.reg_address !== exp.reg_address || got.reg_value !== exp.reg_value ||
                got.last !== exp.last || got.rejected !== exp.rejected)
                report_mismatch($sformatf(
                    "got reg %0d val %02h last %b rej %b, want reg %0d val %02h last %b rej %b",
                    got.reg_address, got.reg_value, got.last, got.rejected,
                    exp.reg_address, exp.reg_value, exp.last, exp.rejected));
        endtask

        function int pending();
            return expected_writes.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_req                 i_req;
    logic                 o_res_strobe;
    t_res                 o_res;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    taskfile_scoreboard   sb;
    int                   cycle_count;

    ata_taskfile_address_builder u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req        (i_req),
        .o_res_strobe (o_res_strobe),
        .o_res        (o_res),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Check every write as it is shown; the receiver never stalls
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_strobe)
            sb.check_write(o_res);
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    function automatic t_req make_req(logic op, logic [27:0] lba, logic [8:0] count);
        t_req r;
        r.operation     = op;
        r.block_address = lba;
        r.sector_count  = count;
        return r;
    endfunction

    // Mostly valid counts, with refusals and the extremes mixed in
    function automatic t_req random_request();
        logic [27:0] lba;
        logic [8:0]  count;
        case ($urandom_range(0, 3))
            0:       lba = 28'($urandom_range(0, 4095));
            1:       lba = 28'hFFFFFFF - 28'($urandom_range(0, 255));
            default: lba = 28'($urandom());
        endcase
        case ($urandom_range(0, 19))
            0:       count = 9'd0;
            1:       count = 9'($urandom_range(257, 511));
            2:       count = 9'd256;
            default: count = 9'($urandom_range(1, 256));
        endcase
        return make_req(1'($urandom_range(0, 1)), lba, count);
    endfunction

    // Hold the item until the block takes it
    task automatic send_item(t_req r);
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        sb.note_request(r);
    endtask

    // Drop start and wait for every outstanding write, then let the pipe empty
    task automatic wait_drained();
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(t_cfg_idx idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_register(idx, value);
    endtask

    task automatic configure(logic mode, logic [7:0] spt_val, logic [4:0] heads_val);
        wait_drained();
        write_register(CFG_LBA_MODE, {31'd0, mode});
        write_register(CFG_SPT, {24'd0, spt_val});
        write_register(CFG_HEADS, {27'd0, heads_val});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Send items in bursts with random gaps; now and then let everything drain
    task automatic run_random_items(int n);
        int remaining;
        int burst;
        int gap;
        remaining = n;
        while (remaining > 0) begin
            burst = $urandom_range(1, 8);
            while (burst > 0 && remaining > 0) begin
                send_item(random_request());
                burst--;
                remaining--;
                if ($urandom_range(0, 24) == 0)
                    wait_drained();
            end
            gap = $urandom_range(0, 9);
            if (gap > 0) begin
                start <= 1'b0;
                i_req <= random_request();
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    initial begin
        sb          = new();
        cycle_count = 0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_req       = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // LBA28 with reset geometry: address and count extremes, refusals
        send_item(make_req(1'b0, 28'h0000000, 9'd1));
        send_item(make_req(1'b1, 28'hFFFFFFF, 9'd256));
        send_item(make_req(1'b0, 28'hA5A5A5A, 9'd0));
        send_item(make_req(1'b1, 28'h5A5A5A5, 9'd511));
        send_item(make_req(1'b0, 28'h1234567, 9'd257));
        send_item(make_req(1'b1, 28'h0FEDCBA, 9'd255));
        run_random_items(15);

        // CHS with common geometry: track and head boundaries, cylinder wrap
        configure(1'b0, 8'd63, 5'd16);
        send_item(make_req(1'b0, 28'd0, 9'd1));
        send_item(make_req(1'b1, 28'd62, 9'd8));
        send_item(make_req(1'b0, 28'd63, 9'd16));
        send_item(make_req(1'b1, 28'd1007, 9'd128));
        send_item(make_req(1'b0, 28'd1008, 9'd2));
        send_item(make_req(1'b1, 28'hFFFFFFF, 9'd256));
        send_item(make_req(1'b0, 28'd500, 9'd0));
        run_random_items(15);

        // One sector per track and one head: cylinder is the low address bits
        configure(1'b0, 8'd1, 5'd1);
        run_random_items(15);

        // Widest geometry, head count above sixteen
        configure(1'b0, 8'd255, 5'd31);
        send_item(make_req(1'b1, 28'hFFFFFFF, 9'd3));
        send_item(make_req(1'b0, 28'd5100, 9'd4));
        send_item(make_req(1'b1, 28'd7904, 9'd5));
        run_random_items(15);

        // Zero geometry values fall back to one
        configure(1'b0, 8'd0, 5'd0);
        send_item(make_req(1'b0, 28'd5, 9'd3));
        send_item(make_req(1'b1, 28'hFFFFFFF, 9'd1));
        run_random_items(15);

        repeat (2) begin
            configure(1'b0, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)));
            run_random_items(18);
        end

        // LBA28 again with odd geometry left behind
        configure(1'b1, 8'd200, 5'd3);
        run_random_items(18);

        configure(1'b0, 8'd255, 5'd16);
        run_random_items(16);

        wait_drained();
        if (sb.errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
